/* design/cpit_pkg.sv */
// ----------------------------------------------------------------------------
// cpit_pkg
// Shared types, codes and defaults for the chained periodic interrupt timer.
// ----------------------------------------------------------------------------
package cpit_pkg;

    // Default sizing
    localparam int CPIT_CHANNEL_COUNT = 4;
    localparam int CPIT_COUNT_WIDTH   = 32;

    // Fixed field widths
    localparam int KIND_W  = 2;
    localparam int CHIDX_W = 2;
    localparam int SEL_W   = 3;
    localparam int DATA_W  = 32;
    localparam int IRQ_W   = 4;
    localparam int CTRL_W  = 3;

    // Item kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_TICK  = 2'd0,
        KIND_READ  = 2'd1,
        KIND_WRITE = 2'd2
    } kind_t;

    // Register select codes
    localparam logic [SEL_W-1:0] REG_RELOAD  = 3'd0;
    localparam logic [SEL_W-1:0] REG_COUNT   = 3'd1;
    localparam logic [SEL_W-1:0] REG_CONTROL = 3'd2;
    localparam logic [SEL_W-1:0] REG_FLAG    = 3'd3;
    localparam logic [SEL_W-1:0] REG_LIFE_HI = 3'd4;
    localparam logic [SEL_W-1:0] REG_LIFE_LO = 3'd5;

    // Control bit positions
    localparam int CTRL_EN_BIT     = 0;
    localparam int CTRL_IRQ_EN_BIT = 1;
    localparam int CTRL_CHAIN_BIT  = 2;

    // Flag write bit
    localparam int FLAG_CLEAR_BIT = 0;

endpackage

/* design/chained_periodic_interrupt_timer.sv */
// ----------------------------------------------------------------------------
// chained_periodic_interrupt_timer
// Multi-channel down-counting periodic timer with channel chaining, expiry
// flags, interrupt lines and a latched lifetime read.
// ----------------------------------------------------------------------------
//
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------
//  in      | in_valid/in_stall  | kind, channel_index, reg_select, write_data
//  out     | out_valid/out_stall| read_data, irq_lines
//
//  The tick, read or write of each item is resolved in one pass of logic
//  on the channel registers and lands in the result register at the
//  accepting edge. One item is accepted per cycle while in_stall is low; the
//  chain ripple through the channels sets the critical path.
//  Reset clears all channel state and empties the result register.
//  in_stall rises only while a result is held under out_stall.
//
module chained_periodic_interrupt_timer
    import cpit_pkg::*;
#(
    parameter int CHANNEL_COUNT = CPIT_CHANNEL_COUNT,
    parameter int COUNT_WIDTH   = CPIT_COUNT_WIDTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [KIND_W-1:0]  kind,
    input  logic [CHIDX_W-1:0] channel_index,
    input  logic [SEL_W-1:0]   reg_select,
    input  logic [DATA_W-1:0]  write_data,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [DATA_W-1:0]  read_data,
    output logic [IRQ_W-1:0]   irq_lines
);

    localparam int IRQ_N = (CHANNEL_COUNT < IRQ_W) ? CHANNEL_COUNT : IRQ_W;

    // Channel state
    logic [COUNT_WIDTH-1:0] reload_reg [CHANNEL_COUNT];
    logic [COUNT_WIDTH-1:0] reload_next[CHANNEL_COUNT];
    logic [COUNT_WIDTH-1:0] count_reg  [CHANNEL_COUNT];
    logic [COUNT_WIDTH-1:0] count_next [CHANNEL_COUNT];
    logic [CTRL_W-1:0]      ctrl_reg   [CHANNEL_COUNT];
    logic [CTRL_W-1:0]      ctrl_next  [CHANNEL_COUNT];
    logic [CHANNEL_COUNT-1:0] flag_reg;
    logic [CHANNEL_COUNT-1:0] flag_next;
    logic [COUNT_WIDTH-1:0] latch_reg;
    logic [COUNT_WIDTH-1:0] latch_next;

    // Result register
    logic              out_valid_reg;
    logic [DATA_W-1:0] read_data_reg;
    logic [DATA_W-1:0] read_data_next;
    logic [IRQ_W-1:0]  irq_reg;
    logic [IRQ_W-1:0]  irq_next;
    logic [IRQ_W-1:0]  irq_now;

    logic in_accept;
    logic is_tick;
    logic is_read;
    logic is_write;

    // Accept whenever the result register is free or being emptied
    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;
    assign is_tick   = (kind_t'(kind) == KIND_TICK);
    assign is_read   = (kind_t'(kind) == KIND_READ);
    assign is_write  = (kind_t'(kind) == KIND_WRITE);

    // Resolve the item: tick ripple, register write, read mux
    always_comb
    begin
        logic below_expired;
        logic counts;
        logic hit;
        below_expired  = 1'b0;
        latch_next     = latch_reg;
        flag_next      = flag_reg;
        read_data_next = '0;
        for (int i = 0; i < CHANNEL_COUNT; i++)
        begin
            reload_next[i] = reload_reg[i];
            count_next[i]  = count_reg[i];
            ctrl_next[i]   = ctrl_reg[i];
            hit            = (int'(channel_index) == i);

            // Advance the counter on a tick; chained channels wait for the one below
            counts = 1'b0;
            if (ctrl_reg[i][CTRL_EN_BIT])
            begin
                if (i != 0 && ctrl_reg[i][CTRL_CHAIN_BIT])
                    counts = below_expired;
                else
                    counts = 1'b1;
            end
            counts        = counts && is_tick;
            below_expired = 1'b0;
            if (counts)
            begin
                if (count_reg[i] == '0)
                begin
                    count_next[i] = reload_reg[i];
                    flag_next[i]  = 1'b1;
                    below_expired = 1'b1;
                end
                else
                begin
                    count_next[i] = count_reg[i] - COUNT_WIDTH'(1);
                end
            end

            // Apply a write to the addressed channel
            if (is_write && hit)
            begin
                case (reg_select)
                    REG_RELOAD:
                    begin
                        reload_next[i] = write_data[COUNT_WIDTH-1:0];
                    end
                    REG_CONTROL:
                    begin
                        ctrl_next[i] = write_data[CTRL_W-1:0];
                        if (!ctrl_reg[i][CTRL_EN_BIT] && write_data[CTRL_EN_BIT])
                            count_next[i] = reload_reg[i];
                    end
                    REG_FLAG:
                    begin
                        if (write_data[FLAG_CLEAR_BIT])
                            flag_next[i] = 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end

            // Collect per-channel read data
            if (is_read && hit)
            begin
                case (reg_select)
                    REG_RELOAD:  read_data_next = DATA_W'(reload_reg[i]);
                    REG_COUNT:   read_data_next = DATA_W'(count_reg[i]);
                    REG_CONTROL: read_data_next = DATA_W'(ctrl_reg[i]);
                    REG_FLAG:    read_data_next = DATA_W'(flag_reg[i]);
                    default:
                    begin
                    end
                endcase
            end
        end

        // Lifetime words ignore the channel index
        if (is_read && reg_select == REG_LIFE_HI)
        begin
            latch_next     = count_reg[0];
            read_data_next = DATA_W'(count_reg[1]);
        end
        if (is_read && reg_select == REG_LIFE_LO)
            read_data_next = DATA_W'(latch_reg);

        // Interrupt lines after this item's update
        irq_next = '0;
        for (int i = 0; i < IRQ_N; i++)
            irq_next[i] = flag_next[i] && ctrl_next[i][CTRL_IRQ_EN_BIT];
    end

    // Interrupt lines of the present state
    always_comb
    begin
        irq_now = '0;
        for (int i = 0; i < IRQ_N; i++)
            irq_now[i] = flag_reg[i] && ctrl_reg[i][CTRL_IRQ_EN_BIT];
    end

    // Update channel state on an accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNEL_COUNT; i++)
            begin
                reload_reg[i] <= '0;
                count_reg[i]  <= '0;
                ctrl_reg[i]   <= '0;
            end
            flag_reg  <= '0;
            latch_reg <= '0;
        end
        else if (in_accept)
        begin
            for (int i = 0; i < CHANNEL_COUNT; i++)
            begin
                reload_reg[i] <= reload_next[i];
                count_reg[i]  <= count_next[i];
                ctrl_reg[i]   <= ctrl_next[i];
            end
            flag_reg  <= flag_next;
            latch_reg <= latch_next;
        end
    end

    // Hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_accept)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            read_data_reg <= read_data_next;
            irq_reg       <= irq_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;
    assign irq_lines = irq_reg;

    // Checks
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid_reg)
        else $error("input stalled with an empty result register");

    a_nonread_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !is_read) |=> (read_data == '0))
        else $error("non-read item returned nonzero read data");

    a_irq_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (irq_lines == irq_now))
        else $error("interrupt lines disagree with channel state");

    a_state_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !in_accept |=> ($stable(flag_reg) && $stable(latch_reg)))
        else $error("channel state changed without an accepted item");

endmodule
